// ===== design/egcd_pkg.sv =====
// ----------------------------------------------------------------------------
// egcd_pkg: shared constants and types for the extended GCD unit
// Field widths and the control and status groups that pass between the
// sequencer and the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

package egcd_pkg;

	// Default operand width (each operand is taken modulo 2^OPERAND_BITS)
	localparam int unsigned OPERAND_BITS = 31;

	// Fixed widths of the result fields
	localparam int unsigned DIV_BITS  = 31;
	localparam int unsigned COEF_BITS = 32;

	// Sequencer to divider
	typedef struct packed {
		logic start;
	} div_ctrl_t;

	// Divider to sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ===== design/egcd_divider.sv =====
// ----------------------------------------------------------------------------
// egcd_divider: shared restoring divider with quotient-weighted accumulation
// One quotient bit per cycle, MSB first. As each bit appears, two accumulators
// fold it in Horner style, so at the end they hold q*mul_x and q*mul_y
// modulo 2^COEF_BITS without a multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module egcd_divider #(
	parameter int unsigned OPERAND_BITS = egcd_pkg::OPERAND_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire egcd_pkg::div_ctrl_t             ctrl,
	input  wire logic [OPERAND_BITS-1:0]         dividend,
	input  wire logic [OPERAND_BITS-1:0]         divisor_in,
	input  wire logic [egcd_pkg::COEF_BITS-1:0]  mul_x,
	input  wire logic [egcd_pkg::COEF_BITS-1:0]  mul_y,
	output egcd_pkg::div_stat_t                  stat,
	output logic [OPERAND_BITS-1:0]              remainder,
	output logic [egcd_pkg::COEF_BITS-1:0]       prod_x,
	output logic [egcd_pkg::COEF_BITS-1:0]       prod_y
);

	localparam int unsigned N    = OPERAND_BITS;
	localparam int unsigned C    = egcd_pkg::COEF_BITS;
	localparam int unsigned CntW = (N > 1) ? $clog2(N) : 1;

	logic            busy_q;
	logic            done_q;
	logic [CntW-1:0] cnt_q;

	logic [N-1:0] rem_q;
	logic [N-1:0] quo_q;
	logic [N-1:0] dvs_q;
	logic [C-1:0] mx_q;
	logic [C-1:0] my_q;
	logic [C-1:0] ax_q;
	logic [C-1:0] ay_q;

	logic [N:0] shifted;
	logic [N:0] diff;
	logic       take;

	// trial subtract of the divisor from the partial remainder
	assign shifted = {rem_q, quo_q[N-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign take    = ~diff[N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(N - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor_in;
			mx_q  <= mul_x;
			my_q  <= mul_y;
			ax_q  <= '0;
			ay_q  <= '0;
		end else if (busy_q) begin
			rem_q <= take ? diff[N-1:0] : shifted[N-1:0];
			quo_q <= quo_q << 1;
			ax_q  <= (ax_q << 1) + (take ? mx_q : '0);
			ay_q  <= (ay_q << 1) + (take ? my_q : '0);
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;
	assign prod_x    = ax_q;
	assign prod_y    = ay_q;

endmodule

`default_nettype wire

// ===== design/extended_gcd_unit.sv =====
// ----------------------------------------------------------------------------
// extended_gcd_unit: greatest common divisor with Bezout coefficients
// Iterative extended Euclid around one shared serial divider.
// ----------------------------------------------------------------------------
// Takes a request (first_value = a, second_value = b), each taken modulo
// 2^OPERAND_BITS, and returns divisor = gcd(a, b) with coefficients
// coeff_first (x) and coeff_second (y) so that a*x + b*y = gcd, in 32-bit
// two's complement. b = 0 gives gcd = a, x = 1, y = 0. One request is in
// work at a time: in_ready is low from acceptance until the result has been
// moved into the output register. A request with b = 0 skips the divider;
// otherwise each Euclid pass is one division in the shared divider (start,
// one quotient bit per cycle, then write-back), and 31-bit operands need at
// most about 45 passes. The output register lets the next request be
// accepted while a result waits for out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module extended_gcd_unit #(
	parameter int unsigned OPERAND_BITS = egcd_pkg::OPERAND_BITS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [OPERAND_BITS-1:0]               first_value,
	input  wire logic [OPERAND_BITS-1:0]               second_value,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [egcd_pkg::DIV_BITS-1:0]              divisor,
	output logic signed [egcd_pkg::COEF_BITS-1:0]      coeff_first,
	output logic signed [egcd_pkg::COEF_BITS-1:0]      coeff_second
);

	localparam int unsigned N    = OPERAND_BITS;
	localparam int unsigned C    = egcd_pkg::COEF_BITS;
	localparam int unsigned DivW = egcd_pkg::DIV_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_FINISH
	} state_t;

	state_t state_q;

	// Euclid working set: (a, b) remainders, (px, py) coefficients of a,
	// (cx, cy) coefficients of b
	logic [N-1:0] a_q;
	logic [N-1:0] b_q;
	logic [C-1:0] px_q;
	logic [C-1:0] py_q;
	logic [C-1:0] cx_q;
	logic [C-1:0] cy_q;

	logic                   out_valid_q;
	logic [DivW-1:0]        divisor_q;
	logic [C-1:0]           coeff_first_q;
	logic [C-1:0]           coeff_second_q;

	egcd_pkg::div_ctrl_t div_ctrl;
	egcd_pkg::div_stat_t div_stat;
	logic [N-1:0]        div_rem;
	logic [C-1:0]        div_px;
	logic [C-1:0]        div_py;

	logic in_fire;
	logic out_free;
	logic out_load;

	assign in_ready       = (state_q == ST_IDLE);
	assign in_fire        = in_valid && in_ready;
	assign out_free       = !out_valid_q || out_ready;
	assign out_load       = (state_q == ST_FINISH) && out_free;
	assign div_ctrl.start = (state_q == ST_START);

	egcd_divider #(
		.OPERAND_BITS (OPERAND_BITS)
	) u_divider (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (div_ctrl),
		.dividend   (a_q),
		.divisor_in (b_q),
		.mul_x      (cx_q),
		.mul_y      (cy_q),
		.stat       (div_stat),
		.remainder  (div_rem),
		.prod_x     (div_px),
		.prod_y     (div_py)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			out_valid_q    <= 1'b0;
			divisor_q      <= '0;
			coeff_first_q  <= '0;
			coeff_second_q <= '0;
		end else begin
			// a new result replaces the one leaving in the same cycle
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						// b = 0 needs no pass: result is (a, 1, 0)
						state_q <= (second_value == '0) ? ST_FINISH : ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_stat.done) begin
						state_q <= (div_rem == '0) ? ST_FINISH : ST_START;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						divisor_q      <= DivW'(a_q);
						coeff_first_q  <= px_q;
						coeff_second_q <= py_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working set: load on request, rotate on each finished division
	always_ff @(posedge clk) begin
		if (in_fire) begin
			a_q  <= first_value;
			b_q  <= second_value;
			px_q <= C'(1);
			py_q <= '0;
			cx_q <= '0;
			cy_q <= C'(1);
		end else if ((state_q == ST_WAIT) && div_stat.done) begin
			a_q  <= b_q;
			b_q  <= div_rem;
			px_q <= cx_q;
			py_q <= cy_q;
			cx_q <= px_q - div_px;
			cy_q <= py_q - div_py;
		end
	end

	assign out_valid    = out_valid_q;
	assign divisor      = divisor_q;
	assign coeff_first  = coeff_first_q;
	assign coeff_second = coeff_second_q;

endmodule

`default_nettype wire

// ===== test/extended_gcd_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_gcd_unit_test: self-checking bench for the extended GCD unit
// Drives operand requests through the valid/ready input channel and checks
// every result against a local extended Euclid predictor (64-bit wrapping
// coefficients, reported at field width). Directed special cases come first,
// then a long random mix, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------

module extended_gcd_unit_test;

	localparam int OP_W = egcd_pkg::OPERAND_BITS;
	localparam logic [OP_W-1:0] OPERAND_MAX = '1;
	localparam int WATCHDOG_LIMIT = 20000;  // cycles with no handshake on either side
	localparam int DRAIN_CYCLES = 1600;     // extra run time after the last result is checked

	// One result as the unit reports it
	typedef struct packed {
		logic [egcd_pkg::DIV_BITS-1:0]         divisor;
		logic signed [egcd_pkg::COEF_BITS-1:0] coeff_first;
		logic signed [egcd_pkg::COEF_BITS-1:0] coeff_second;
	} bezout_t;

	logic                                  clk;
	logic                                  arst_n;
	logic                                  in_valid;
	logic                                  in_ready;
	logic [OP_W-1:0]                       first_value;
	logic [OP_W-1:0]                       second_value;
	logic                                  out_valid;
	logic                                  out_ready;
	logic [egcd_pkg::DIV_BITS-1:0]         divisor;
	logic signed [egcd_pkg::COEF_BITS-1:0] coeff_first;
	logic signed [egcd_pkg::COEF_BITS-1:0] coeff_second;

	bezout_t pending_bezout[$];  // predicted results, oldest first
	int      mismatch_count;
	int      quiet_cycles;
	int      burst_left;
	bit      idle_on;

	extended_gcd_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.first_value  (first_value),
		.second_value (second_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.divisor      (divisor),
		.coeff_first  (coeff_first),
		.coeff_second (coeff_second)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Extended Euclid: (r_prev, r_cur) walk down the remainder chain while
	// the coefficient pairs follow along. Coefficients wrap at 64 bits and
	// are cut to the 32-bit fields at the end; b = 0 skips the loop and
	// leaves gcd = a, x = 1, y = 0.
	function automatic bezout_t bezout_of(input logic [OP_W-1:0] a, input logic [OP_W-1:0] b);
		logic [63:0] r_prev, r_cur, r_next, quot;
		logic [63:0] x_prev, x_cur, x_next, y_prev, y_cur, y_next;
		bezout_t     res;
		r_prev = 64'(a);
		r_cur  = 64'(b);
		x_prev = 64'd1;
		y_prev = 64'd0;
		x_cur  = 64'd0;
		y_cur  = 64'd1;
		while (r_cur != 64'd0) begin
			quot   = r_prev / r_cur;
			r_next = r_prev - quot * r_cur;
			x_next = x_prev - quot * x_cur;
			y_next = y_prev - quot * y_cur;
			r_prev = r_cur;
			r_cur  = r_next;
			x_prev = x_cur;
			x_cur  = x_next;
			y_prev = y_cur;
			y_cur  = y_next;
		end
		res.divisor      = r_prev[egcd_pkg::DIV_BITS-1:0];
		res.coeff_first  = x_prev[egcd_pkg::COEF_BITS-1:0];
		res.coeff_second = y_prev[egcd_pkg::COEF_BITS-1:0];
		return res;
	endfunction

	// Fibonacci number k (F0 = 0, F1 = 1); consecutive pairs are the slowest
	// inputs for Euclid. F46 is the largest that fits 31 bits.
	function automatic logic [OP_W-1:0] fib_at(input int k);
		logic [63:0] f_lo, f_hi, f_sum;
		f_lo = 64'd0;
		f_hi = 64'd1;
		for (int i = 0; i < k; i++) begin
			f_sum = f_lo + f_hi;
			f_lo  = f_hi;
			f_hi  = f_sum;
		end
		return f_lo[OP_W-1:0];
	endfunction

	// Sends one request. Valid stays high between back-to-back requests and
	// only drops for a gap; gaps come between bursts of random length.
	task automatic send_operands(input logic [OP_W-1:0] a, input logic [OP_W-1:0] b);
		int gap;
		gap = 0;
		if (idle_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			case ($urandom_range(0, 9))
				0: begin
					gap = $urandom_range(100, 1600);  // lands anywhere in a long request
				end
				1, 2, 3: begin
					gap = $urandom_range(1, 40);
				end
				default: begin
					gap = $urandom_range(0, 3);
				end
			endcase
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		first_value  <= a;
		second_value <= b;
		do
			@(posedge clk);
		while (!in_ready);
		pending_bezout.push_back(bezout_of(a, b));
	endtask

	// b = 0 (including a = 0) and a = 0 with b nonzero
	task automatic test_zero_operands();
		send_operands('0, '0);
		send_operands(OP_W'(12345), '0);
		send_operands(OPERAND_MAX, '0);
		send_operands('0, OP_W'(1));
		send_operands('0, OPERAND_MAX);
	endtask

	// Field extremes, equal operands, ones, powers of two, multiples, primes
	task automatic test_extreme_operands();
		send_operands(OP_W'(1), OP_W'(1));
		send_operands(OPERAND_MAX, OPERAND_MAX);
		send_operands(OPERAND_MAX, OP_W'(1));
		send_operands(OP_W'(1), OPERAND_MAX);
		send_operands(OPERAND_MAX, OPERAND_MAX - OP_W'(1));
		send_operands(OP_W'(1) << (OP_W - 1), OP_W'(1) << (OP_W - 2));
		send_operands(OP_W'(240), OP_W'(46));
		send_operands(OP_W'(46), OP_W'(240));
		send_operands(OP_W'(2997), OP_W'(999));
		send_operands(OP_W'(1000000007), OP_W'(998244353));
	endtask

	// Consecutive Fibonacci pairs; F46 and F45 take the most passes the unit can take
	task automatic test_slow_sequences();
		send_operands(fib_at(46), fib_at(45));
		send_operands(fib_at(45), fib_at(46));
		send_operands(fib_at(45), fib_at(44));
		send_operands(fib_at(30), fib_at(29));
	endtask

	// Random mix in four phases; one phase runs with no sender idling
	task automatic test_random_operands();
		logic [OP_W-1:0] a, b;
		int unsigned     scale, k;
		for (int phase = 0; phase < 4; phase++) begin
			idle_on    = (phase != 2);
			burst_left = 0;
			for (int n = 0; n < 100; n++) begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
						a = OP_W'($urandom);
						b = OP_W'($urandom);
					end
					10, 11, 12: begin
						// shared factor, so the gcd is often large
						scale = $urandom_range(1, 65535);
						a = OP_W'(scale * $urandom_range(0, 32767));
						b = OP_W'(scale * $urandom_range(0, 32767));
					end
					13, 14, 15: begin
						a = OP_W'($urandom_range(0, 255));
						b = OP_W'($urandom_range(0, 255));
					end
					16, 17: begin
						k = $urandom_range(1, 45);
						a = fib_at(k + 1);
						b = fib_at(k);
						if ($urandom_range(0, 1))
							{a, b} = {b, a};
					end
					18: begin
						a = OP_W'($urandom);
						b = '0;
						if ($urandom_range(0, 1))
							{a, b} = {b, a};
					end
					default: begin
						a = OPERAND_MAX - OP_W'($urandom_range(0, 15));
						b = OPERAND_MAX - OP_W'($urandom_range(0, 15));
					end
				endcase
				send_operands(a, b);
			end
		end
	endtask

	// Stimulus and end of run
	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		first_value    = '0;
		second_value   = '0;
		mismatch_count = 0;
		burst_left     = 0;
		idle_on        = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_zero_operands();
		test_extreme_operands();
		test_slow_sequences();
		test_random_operands();

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_bezout.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("extended_gcd_unit_test: done, clean");
		else
			$display("extended_gcd_unit_test: done, errors");
		$finish;
	end

	// Receiver: ready follows a 16-bit stall pattern that changes from time
	// to time; about a quarter of the spans never stall.
	initial begin
		logic [15:0] stall_pattern;
		int          span;
		out_ready = 1'b0;
		forever begin
			if ($urandom_range(0, 3) == 0)
				stall_pattern = '1;
			else
				stall_pattern = 16'($urandom) | 16'h0001;
			span = $urandom_range(50, 2000);
			for (int k = 0; k < span; k++) begin
				@(negedge clk);
				out_ready <= stall_pattern[k % 16];
			end
		end
	end

	// Result check against the oldest prediction
	always @(posedge clk) begin
		bezout_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_bezout.size() == 0) begin
				$display("%0t: result with no request pending: divisor %0d x %0d y %0d",
					$time, divisor, coeff_first, coeff_second);
				mismatch_count++;
			end else begin
				want = pending_bezout.pop_front();
				if (divisor !== want.divisor) begin
					$display("%0t: divisor expected %0d, actual %0d",
						$time, want.divisor, divisor);
					mismatch_count++;
				end
				if (coeff_first !== want.coeff_first) begin
					$display("%0t: coeff_first expected %0d, actual %0d",
						$time, want.coeff_first, coeff_first);
					mismatch_count++;
				end
				if (coeff_second !== want.coeff_second) begin
					$display("%0t: coeff_second expected %0d, actual %0d",
						$time, want.coeff_second, coeff_second);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: too long with no request or result moving ends the run
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("extended_gcd_unit_test: done, errors");
			$finish;
		end
	end

	initial quiet_cycles = 0;

endmodule

// ===== sim.f =====
design/egcd_pkg.sv
design/egcd_divider.sv
design/extended_gcd_unit.sv
test/extended_gcd_unit_test.sv
